@@ design/assert_macros.svh @@
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted (active low)
`define PTD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Clocked assertion that is also checked during reset
`define PTD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/ptd_pkg.sv @@
// Package for the periodic task dispatcher: widths, codes and interface types
`timescale 1ns / 1ps

package ptd_pkg;

    localparam int DATA_W        = 16;
    localparam int TT_W          = 10;
    localparam int FUNC_W        = 2;
    localparam int ID_W          = 3;
    localparam int MASK_W        = 8;
    localparam int NUM_TASKS_DEF = 8;

    localparam logic [TT_W-1:0] TT_RESET = TT_W'(1);

    localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CREATE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SET    = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ID_W-1:0]   task_id;
        logic [DATA_W-1:0] period_ms;
        logic [DATA_W-1:0] initial_delay;
        logic              ready_req;
    } t_in_item;

    typedef struct packed {
        logic [MASK_W-1:0] due_mask;
        logic [DATA_W-1:0] tick_value;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic load;       // input transfer: latch item, apply set/delete
        logic div_start;  // launch the serial divider
        logic mask_upd;   // fold divider remainder into the due mask
        logic slot_next;  // advance the slot walk
        logic create_wr;  // write the created task
        logic out_load;   // fill the result register, bump the tick counter
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [FUNC_W-1:0] in_func;
        logic              div_done;
        logic              slot_elig;
        logic              slot_last;
    } t_sts;

endpackage

@@ design/ptd_div.sv @@
// Restoring serial divider, one quotient bit per cycle
`timescale 1ns / 1ps

module ptd_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [ptd_pkg::DATA_W-1:0] i_dividend,
    input  logic [ptd_pkg::DATA_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [ptd_pkg::DATA_W-1:0] o_quot,
    output logic [ptd_pkg::DATA_W-1:0] o_rem
);

    localparam int W     = ptd_pkg::DATA_W;
    localparam int CNT_W = $clog2(W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_dvs;

    logic [W:0]       w_trial;
    logic [W:0]       w_diff;
    logic             w_ge;
    logic [W-1:0]     n_rem;
    logic [W-1:0]     n_quo;

    always_comb begin
        w_trial = {r_rem, r_quo[W-1]};
        w_diff  = w_trial - {1'b0, r_dvs};
        w_ge    = (w_trial >= {1'b0, r_dvs});
        n_rem   = w_ge ? w_diff[W-1:0] : w_trial[W-1:0];
        n_quo   = {r_quo[W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out of the quotient register as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

@@ design/ptd_dp.sv @@
// Datapath: task table, tick counter, configuration register, divider, result register
`timescale 1ns / 1ps

module ptd_dp #(
    parameter int NUM_TASKS = ptd_pkg::NUM_TASKS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  ptd_pkg::t_cmd           i_cmd,
    output ptd_pkg::t_sts           o_sts,
    input  ptd_pkg::t_in_item       i_in,
    input  logic                    i_cfg_we,
    input  logic [ptd_pkg::TT_W-1:0] i_cfg_data,
    output ptd_pkg::t_out_item      o_out
);

    localparam int W      = ptd_pkg::DATA_W;
    localparam int TT_W   = ptd_pkg::TT_W;
    localparam int MASK_W = ptd_pkg::MASK_W;
    localparam int ID_W   = ptd_pkg::ID_W;
    localparam int SLOT_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

    logic [TT_W-1:0]         r_tt;
    logic [W-1:0]            r_tick;
    logic [NUM_TASKS-1:0]    r_valid;
    logic [NUM_TASKS-1:0]    r_ready;
    logic [W-1:0]            r_period [NUM_TASKS];
    logic [ptd_pkg::FUNC_W-1:0] r_func;
    logic [ID_W-1:0]         r_id;
    logic [W-1:0]            r_sum;
    logic [SLOT_W-1:0]       r_slot;
    logic [MASK_W-1:0]       r_mask;
    ptd_pkg::t_out_item      r_out;

    logic [TT_W-1:0]         w_tt;
    logic [2*W-1:0]          w_prod;
    logic [W-1:0]            n_sum;
    logic [W-1:0]            w_per;
    logic                    w_is_tick;
    logic [W-1:0]            w_dividend;
    logic [W-1:0]            w_divisor;
    logic                    w_div_done;
    logic [W-1:0]            w_quot;
    logic [W-1:0]            w_rem;

    // a tick time of zero behaves as one
    assign w_tt   = (r_tt == '0) ? TT_W'(1) : r_tt;
    assign w_prod = i_in.initial_delay * {{(W-TT_W){1'b0}}, w_tt};
    assign n_sum  = i_in.period_ms + w_prod[W-1:0];
    assign w_per  = r_period[r_slot];

    assign w_is_tick  = (r_func == ptd_pkg::FUNC_TICK);
    assign w_dividend = w_is_tick ? r_tick : r_sum;
    assign w_divisor  = w_is_tick ? w_per : {{(W-TT_W){1'b0}}, w_tt};

    ptd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tt    <= ptd_pkg::TT_RESET;
            r_tick  <= '0;
            r_valid <= '0;
            r_ready <= '0;
        end else begin
            if (i_cfg_we) begin
                r_tt <= i_cfg_data;
            end
            if (i_cmd.out_load) begin
                r_tick <= r_tick + W'(1);
            end
            for (int i = 0; i < NUM_TASKS; i++) begin
                if (i_cmd.load && int'(i_in.task_id) == i) begin
                    if (i_in.func == ptd_pkg::FUNC_SET) begin
                        r_ready[i] <= i_in.ready_req;
                    end else if (i_in.func == ptd_pkg::FUNC_DELETE) begin
                        r_valid[i] <= 1'b0;
                    end
                end
                if (i_cmd.create_wr && int'(r_id) == i) begin
                    r_valid[i] <= 1'b1;
                    r_ready[i] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_TASKS; i++) begin
            if (i_cmd.create_wr && int'(r_id) == i) begin
                r_period[i] <= w_quot;
            end
        end
        if (i_cmd.load) begin
            r_func <= i_in.func;
            r_id   <= i_in.task_id;
            r_sum  <= n_sum;
            r_slot <= '0;
            r_mask <= '0;
        end else begin
            if (i_cmd.mask_upd && w_rem == '0) begin
                // slots past the mask width shift out to nothing
                r_mask <= r_mask | (MASK_W'(1) << r_slot);
            end
            if (i_cmd.slot_next) begin
                r_slot <= r_slot + SLOT_W'(1);
            end
        end
        if (i_cmd.out_load) begin
            r_out.due_mask   <= r_mask;
            r_out.tick_value <= r_tick;
        end
    end

    always_comb begin
        o_sts.in_func   = i_in.func;
        o_sts.div_done  = w_div_done;
        o_sts.slot_elig = r_valid[r_slot] && r_ready[r_slot] && (w_per != '0);
        o_sts.slot_last = (r_slot == SLOT_W'(NUM_TASKS - 1));
    end

    assign o_out = r_out;

endmodule

@@ design/ptd_ctrl.sv @@
// Controller: sequences item handling, the slot walk and the result handshake
`timescale 1ns / 1ps

module ptd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  ptd_pkg::t_sts i_sts,
    output ptd_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CSTART = 3'd1;
    localparam logic [2:0] S_CWAIT  = 3'd2;
    localparam logic [2:0] S_TSTART = 3'd3;
    localparam logic [2:0] S_TWAIT  = 3'd4;
    localparam logic [2:0] S_TOUT   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_vld;
    logic       n_out_vld;
    logic       w_accept;
    logic       w_out_free;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_vld || !i_out_stall;

    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        n_out_vld = r_out_vld && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.in_func == ptd_pkg::FUNC_TICK) begin
                        n_state = S_TSTART;
                    end else if (i_sts.in_func == ptd_pkg::FUNC_CREATE) begin
                        n_state = S_CSTART;
                    end
                end
            end
            S_CSTART: begin
                o_cmd.div_start = 1'b1;
                n_state = S_CWAIT;
            end
            S_CWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.create_wr = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_TSTART: begin
                if (i_sts.slot_elig) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_TWAIT;
                end else if (i_sts.slot_last) begin
                    n_state = S_TOUT;
                end else begin
                    o_cmd.slot_next = 1'b1;
                end
            end
            S_TWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.mask_upd = 1'b1;
                    if (i_sts.slot_last) begin
                        n_state = S_TOUT;
                    end else begin
                        o_cmd.slot_next = 1'b1;
                        n_state = S_TSTART;
                    end
                end
            end
            S_TOUT: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_vld = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;

endmodule

@@ design/periodic_task_dispatcher_top.sv @@
// Top level of the periodic task dispatcher
`timescale 1ns / 1ps

// Time-triggered task dispatcher. Set-state and delete items are applied on
// acceptance. A create item converts the period to ticks: period plus initial
// delay times tick time is divided by the tick time in a 16-step serial
// divider. A tick item walks the NUM_TASKS slots one at a time: an eligible
// slot (valid, ready, nonzero period) uses the same divider to form counter
// mod period, any other slot is skipped, and the result then waits for the
// previous one to be taken. The result sits in an output register, so the
// next item is taken while it waits. Slots at or above the mask width never
// show in due_mask; task ids at or above NUM_TASKS are ignored. The tick-time
// register is written through its own port; the user must write it only while
// no item is in flight (not enforced by the block); a value of zero acts as one.
module periodic_task_dispatcher_top #(
    parameter int NUM_TASKS = ptd_pkg::NUM_TASKS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  ptd_pkg::t_in_item        i_in,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output ptd_pkg::t_out_item       o_out,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [ptd_pkg::TT_W-1:0] i_cfg_data
);

    ptd_pkg::t_cmd w_cmd;
    ptd_pkg::t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    ptd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    ptd_dp #(
        .NUM_TASKS (NUM_TASKS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_out      (o_out)
    );

endmodule

@@ design/ptd_chk.sv @@
// Port-level checker for the periodic task dispatcher, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ptd_chk (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_stall,
    input ptd_pkg::t_in_item        i_in,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input ptd_pkg::t_out_item       o_out
);

    logic w_in_xfer;
    logic w_out_held;
    logic w_tick_xfer;
    logic w_tbl_xfer;

    assign w_in_xfer   = i_in_valid && !o_in_stall;
    assign w_out_held  = o_out_valid && i_out_stall;
    assign w_tick_xfer = w_in_xfer && (i_in.func == ptd_pkg::FUNC_TICK);
    assign w_tbl_xfer  = w_in_xfer &&
                         (i_in.func == ptd_pkg::FUNC_SET || i_in.func == ptd_pkg::FUNC_DELETE);

    `PTD_ASSERT(a_out_hold, i_clk, i_rst_n, w_out_held |=> o_out_valid, "stalled result dropped")
    `PTD_ASSERT(a_out_stable, i_clk, i_rst_n, w_out_held |=> $stable(o_out), "held result changed")
    `PTD_ASSERT(a_tick_busy, i_clk, i_rst_n, w_tick_xfer |=> o_in_stall, "slot walk not started")
    `PTD_ASSERT(a_table_fast, i_clk, i_rst_n, w_tbl_xfer |=> !o_in_stall, "table update stalled")

endmodule

bind periodic_task_dispatcher_top ptd_chk u_ptd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
